>>> src/tdfsm_pkg.sv
// ----------------------------------------------------------------------------
// tdfsm_pkg
// shared types and constants of the table driven state machine engine
// ----------------------------------------------------------------------------
package tdfsm_pkg;

    localparam int EVENT_ENTRIES = 16;
    localparam int TIMED_ENTRIES = 8;
    localparam int STATE_BITS    = 4;
    localparam int EVENT_BITS    = 8;
    localparam int EIDX_BITS     = $clog2(EVENT_ENTRIES);
    localparam int TIDX_BITS     = $clog2(TIMED_ENTRIES);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [1:0] OP_ADD_EVENT = 2'd0;
    localparam logic [1:0] OP_ADD_TIMED = 2'd1;
    localparam logic [1:0] OP_TRIGGER   = 2'd2;
    localparam logic [1:0] OP_RUN       = 2'd3;

    localparam logic [2:0] KIND_INITIAL = 3'd0;
    localparam logic [2:0] KIND_RUN     = 3'd1;
    localparam logic [2:0] KIND_EVENT   = 3'd2;
    localparam logic [2:0] KIND_TIMED   = 3'd3;
    localparam logic [2:0] KIND_NOMATCH = 3'd4;
    localparam logic [2:0] KIND_LOADOK  = 3'd5;
    localparam logic [2:0] KIND_FULL    = 3'd6;

    typedef struct packed {
        logic [1:0]            operation;
        logic [STATE_BITS-1:0] from_state;
        logic [STATE_BITS-1:0] to_state;
        logic [EVENT_BITS-1:0] event_code;
        logic [31:0]           interval;
        logic [31:0]           current_time;
    } cmd_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [STATE_BITS-1:0] prior;
        logic [STATE_BITS-1:0] after;
        logic [3:0]            index;
        logic                  last;
    } res_t;

endpackage

>>> src/tdfsm_queue.sv
// ----------------------------------------------------------------------------
// tdfsm_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module tdfsm_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  tdfsm_pkg::cmd_t   wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output tdfsm_pkg::cmd_t   rd_data
);
    import tdfsm_pkg::*;

    cmd_t mem_reg [QUEUE_DEPTH];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) begin
            mem_reg[wp_reg] <= wr_data;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
        end
    end
endmodule

>>> src/tdfsm_back.sv
// ----------------------------------------------------------------------------
// tdfsm_back
// executes commands: table loads, event search and timed walk
// ----------------------------------------------------------------------------
module tdfsm_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [tdfsm_pkg::STATE_BITS-1:0] cfg_data,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  tdfsm_pkg::cmd_t                  cmd,
    output logic                             res_valid,
    input  logic                             res_ready,
    output tdfsm_pkg::res_t                  res
);
    import tdfsm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVENT = 3'd1;
    localparam logic [2:0] ST_TIMED = 3'd2;
    localparam logic [2:0] ST_ARM   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] st_reg;
    logic [STATE_BITS-1:0] init_reg, cs_reg;
    logic started_reg;
    logic [EIDX_BITS:0] ecnt_reg;
    logic [TIDX_BITS:0] tcnt_reg;
    logic [STATE_BITS-1:0] ev_from [EVENT_ENTRIES];
    logic [STATE_BITS-1:0] ev_to   [EVENT_ENTRIES];
    logic [EVENT_BITS-1:0] ev_code [EVENT_ENTRIES];
    logic [STATE_BITS-1:0] tm_from [TIMED_ENTRIES];
    logic [STATE_BITS-1:0] tm_to   [TIMED_ENTRIES];
    logic [31:0]           tm_int  [TIMED_ENTRIES];
    logic [31:0]           tm_start_reg [TIMED_ENTRIES];
    logic [TIMED_ENTRIES-1:0] tm_armed_reg;
    cmd_t cmd_reg;
    logic [EIDX_BITS:0] i_reg;
    logic [TIDX_BITS:0] arm_reg;
    logic [2:0] ret_reg;
    logic [STATE_BITS-1:0] arm_state_reg;
    logic out_v_reg;
    logic held_reg;
    res_t out_reg;

    logic [EIDX_BITS-1:0] ei;
    logic [TIDX_BITS-1:0] ti, ai;
    logic [31:0] elapsed;
    logic fire;

    assign ei = i_reg[EIDX_BITS-1:0];
    assign ti = i_reg[TIDX_BITS-1:0];
    assign ai = arm_reg[TIDX_BITS-1:0];
    assign elapsed = cmd_reg.current_time - tm_start_reg[ti];
    assign fire = tm_from[ti] == cs_reg && tm_armed_reg[ti] && elapsed >= tm_int[ti];
    assign cmd_ready = st_reg == ST_IDLE && !out_v_reg;
    assign res_valid = out_v_reg;
    assign res = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            init_reg     <= '0;
            cs_reg       <= '0;
            started_reg  <= 1'b0;
            ecnt_reg     <= '0;
            tcnt_reg     <= '0;
            tm_armed_reg <= '0;
            out_v_reg    <= 1'b0;
            held_reg     <= 1'b0;
            for (int k = 0; k < TIMED_ENTRIES; k++) tm_start_reg[k] <= '0;
        end else begin
            if (out_v_reg && res_ready) out_v_reg <= 1'b0;
            if (cfg_we) begin
                init_reg <= cfg_data;
                if (!started_reg) cs_reg <= cfg_data;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (cmd_valid && !out_v_reg) begin
                        cmd_reg <= cmd;
                        i_reg   <= '0;
                        out_reg.prior <= cs_reg;
                        out_reg.after  <= cs_reg;
                        out_reg.index  <= '0;
                        out_reg.last   <= 1'b1;
                        unique case (cmd.operation)
                            OP_ADD_EVENT: begin
                                out_v_reg <= 1'b1;
                                if (ecnt_reg < EVENT_ENTRIES) begin
                                    ev_from[ecnt_reg[EIDX_BITS-1:0]] <= cmd.from_state;
                                    ev_to[ecnt_reg[EIDX_BITS-1:0]]   <= cmd.to_state;
                                    ev_code[ecnt_reg[EIDX_BITS-1:0]] <= cmd.event_code;
                                    out_reg.kind  <= KIND_LOADOK;
                                    out_reg.index <= 4'(ecnt_reg);
                                    ecnt_reg <= ecnt_reg + 1'b1;
                                end else begin
                                    out_reg.kind <= KIND_FULL;
                                end
                            end
                            OP_ADD_TIMED: begin
                                out_v_reg <= 1'b1;
                                if (tcnt_reg < TIMED_ENTRIES) begin
                                    tm_from[tcnt_reg[TIDX_BITS-1:0]] <= cmd.from_state;
                                    tm_to[tcnt_reg[TIDX_BITS-1:0]]   <= cmd.to_state;
                                    tm_int[tcnt_reg[TIDX_BITS-1:0]]  <= cmd.interval;
                                    tm_start_reg[tcnt_reg[TIDX_BITS-1:0]] <= '0;
                                    tm_armed_reg[tcnt_reg[TIDX_BITS-1:0]] <= 1'b0;
                                    out_reg.kind  <= KIND_LOADOK;
                                    out_reg.index <= 4'(tcnt_reg);
                                    tcnt_reg <= tcnt_reg + 1'b1;
                                end else begin
                                    out_reg.kind <= KIND_FULL;
                                end
                            end
                            OP_TRIGGER: begin
                                if (started_reg) begin
                                    st_reg <= ST_EVENT;
                                end else begin
                                    out_reg.kind <= KIND_NOMATCH;
                                    out_v_reg <= 1'b1;
                                end
                            end
                            default: begin
                                out_reg.last  <= 1'b0;
                                if (!started_reg) begin
                                    started_reg  <= 1'b1;
                                    out_v_reg    <= 1'b1;
                                    out_reg.kind <= KIND_INITIAL;
                                    st_reg       <= ST_OUT;
                                end else begin
                                    out_reg.kind <= KIND_RUN;
                                    held_reg     <= 1'b1;
                                    st_reg       <= ST_TIMED;
                                end
                            end
                        endcase
                    end
                end
                ST_EVENT: begin
                    if (i_reg >= ecnt_reg) begin
                        out_reg.kind <= KIND_NOMATCH;
                        out_reg.last <= 1'b1;
                        out_v_reg    <= 1'b1;
                        st_reg       <= ST_IDLE;
                    end else if (ev_from[ei] == cs_reg && ev_code[ei] == cmd_reg.event_code) begin
                        out_reg.kind   <= KIND_EVENT;
                        out_reg.prior <= cs_reg;
                        out_reg.after  <= ev_to[ei];
                        out_reg.index  <= 4'(i_reg);
                        out_reg.last   <= 1'b1;
                        cs_reg         <= ev_to[ei];
                        arm_state_reg  <= ev_to[ei];
                        arm_reg        <= '0;
                        ret_reg        <= ST_IDLE;
                        st_reg         <= ST_ARM;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (!out_v_reg) begin
                        out_reg.kind <= KIND_RUN;
                        held_reg     <= 1'b1;
                        st_reg       <= ST_TIMED;
                    end
                end
                ST_TIMED: begin
                    if (!out_v_reg) begin
                        if (i_reg >= tcnt_reg) begin
                            out_reg.last <= 1'b1;
                            out_v_reg    <= 1'b1;
                            held_reg     <= 1'b0;
                            st_reg       <= ST_IDLE;
                        end else if (fire && held_reg) begin
                            // send the held item before building the next one
                            out_v_reg <= 1'b1;
                            held_reg  <= 1'b0;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                            if (tm_from[ti] == cs_reg) begin
                                if (!tm_armed_reg[ti]) begin
                                    tm_armed_reg[ti] <= 1'b1;
                                    tm_start_reg[ti] <= cmd_reg.current_time;
                                end else if (elapsed >= tm_int[ti]) begin
                                    out_reg.kind   <= KIND_TIMED;
                                    out_reg.prior <= cs_reg;
                                    out_reg.after  <= tm_to[ti];
                                    out_reg.index  <= 4'(ti);
                                    out_reg.last   <= 1'b0;
                                    held_reg       <= 1'b1;
                                    cs_reg         <= tm_to[ti];
                                    arm_state_reg  <= tm_to[ti];
                                    arm_reg        <= '0;
                                    ret_reg        <= ST_TIMED;
                                    st_reg         <= ST_ARM;
                                end
                            end
                        end
                    end
                end
                ST_ARM: begin
                    if (arm_reg >= tcnt_reg) begin
                        if (ret_reg == ST_TIMED) begin
                            tm_armed_reg[ti - 1'b1] <= 1'b0;
                            tm_start_reg[ti - 1'b1] <= '0;
                        end else begin
                            out_v_reg <= 1'b1;
                        end
                        st_reg    <= ret_reg;
                    end else begin
                        if (tm_from[ai] == arm_state_reg) begin
                            tm_armed_reg[ai] <= 1'b1;
                            tm_start_reg[ai] <= cmd_reg.current_time;
                        end
                        arm_reg <= arm_reg + 1'b1;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> src/tdfsm_front.sv
// ----------------------------------------------------------------------------
// tdfsm_front
// input stage: registers the item and does not alter its fields
// ----------------------------------------------------------------------------
module tdfsm_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tdfsm_pkg::cmd_t   in_cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output tdfsm_pkg::cmd_t   q_cmd
);
    import tdfsm_pkg::*;

    logic v_reg;
    cmd_t c_reg;

    assign in_ready = !v_reg || q_ready;
    assign q_valid  = v_reg;
    assign q_cmd    = c_reg;

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            c_reg <= in_cmd;
        end
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end
endmodule

>>> src/table_driven_fsm_with_timed_transitions_top.sv
// ----------------------------------------------------------------------------
// table_driven_fsm_with_timed_transitions_top
// programmable state machine with event and timed transition tables
//
//   channel  direction  handshake
//   s_       in         s_valid / s_ready
//   m_       out        m_valid / m_ready
//   cfg      in         cfg_we, no wait
//
// a load answers once the input item has passed the front register, the
// queue and the back part; a trigger walks the event table one entry per cycle
// and on a match adds an arming sweep over the timed entries; a run walks the
// timed entries one per cycle while no result item waits on m_ready, and each
// firing adds an arming sweep over the timed entries.
// reset is synchronous active low and clears counts and armed bits at once.
// the sequencer in the back part stalls while a result item waits on m_ready.
// ----------------------------------------------------------------------------
module table_driven_fsm_with_timed_transitions_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_from_state,
    input  logic [3:0]  s_to_state,
    input  logic [7:0]  s_event_code,
    input  logic [31:0] s_interval,
    input  logic [31:0] s_current_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_result_kind,
    output logic [3:0]  m_state_before,
    output logic [3:0]  m_state_after,
    output logic [3:0]  m_entry_index,
    output logic        m_last
);
    import tdfsm_pkg::*;

    cmd_t in_cmd, f_cmd, b_cmd;
    logic f_valid, f_ready, b_valid, b_ready;
    res_t res;

    assign in_cmd = '{operation: s_operation, from_state: s_from_state,
                      to_state: s_to_state, event_code: s_event_code,
                      interval: s_interval, current_time: s_current_time};

    tdfsm_front u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready), .in_cmd,
        .q_valid(f_valid), .q_ready(f_ready), .q_cmd(f_cmd)
    );

    tdfsm_queue u_queue (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
    );

    tdfsm_back u_back (
        .aclk, .aresetn, .cfg_we, .cfg_data, .cmd_valid(b_valid), .cmd_ready(b_ready),
        .cmd(b_cmd), .res_valid(m_valid), .res_ready(m_ready), .res
    );

    assign m_result_kind  = res.kind;
    assign m_state_before = res.prior;
    assign m_state_after  = res.after;
    assign m_entry_index  = res.index;
    assign m_last         = res.last;
endmodule
